@@ rtl/core/tcm_pkg.sv @@
// ----------------------------------------------------------------------------
// tcm_pkg - shared types and constants for the trapezoid colour membership
// Breakpoint and ratio layouts, widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package tcm_pkg;

  // Field widths
  localparam int PIX_W     = 8;
  localparam int BP_W      = 9;
  localparam int NUM_CHAN  = 3;
  localparam int SCORE_W   = 8;
  localparam int REG_W     = 4 * BP_W;
  localparam int CFG_IDX_W = 2;

  // Datapath widths: two 9-bit products, three 9-bit products, times 255
  localparam int PROD2_W   = 2 * BP_W;
  localparam int PROD3_W   = 3 * BP_W;
  localparam int SCALED_W  = PROD3_W + SCORE_W;

  // One quotient bit per divider stage
  localparam int DIV_STAGES = SCORE_W;
  // Member stage, two multiplier stages, scale stage, divider stages
  localparam int PIPE_DEPTH = 4 + DIV_STAGES;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHAN2 = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

  // Breakpoints packed as e[35:27] g[26:18] f[17:9] s[8:0]
  typedef struct packed {
    logic [BP_W-1:0] e;
    logic [BP_W-1:0] g;
    logic [BP_W-1:0] f;
    logic [BP_W-1:0] s;
  } bp_t;

  // Membership as numerator over denominator, num <= den, den >= 1
  typedef struct packed {
    logic [BP_W-1:0] num;
    logic [BP_W-1:0] den;
  } ratio_t;

  // Reset breakpoints (s,f,g,e): 10,80,150,240 / 130,140,160,175 / 130,150,170,175
  localparam bp_t CHAN0_BP_RST = 36'd32251617290;
  localparam bp_t CHAN1_BP_RST = 36'd23530117250;
  localparam bp_t CHAN2_BP_RST = 36'd23532743810;

endpackage

@@ rtl/core/tcm_member_stage.sv @@
// ----------------------------------------------------------------------------
// tcm_member_stage - trapezoid membership of each channel
// First pipeline stage: picks the trapezoid segment and registers num/den.
// ----------------------------------------------------------------------------
module tcm_member_stage import tcm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  pix_t   pix   [NUM_CHAN],
  input  bp_t    bp    [NUM_CHAN],
  output logic   out_valid,
  output ratio_t ratio [NUM_CHAN]
);

  // Segment tests in fixed order: above top, falling ramp, flat, rising ramp
  function automatic ratio_t trap_member(bp_t b, pix_t v);
    logic [BP_W-1:0] vx;
    ratio_t          r;
    vx = {1'b0, v};
    priority if (vx >= b.e) begin
      r.num = '0;
      r.den = BP_W'(1);
    end else if (vx >= b.g) begin
      r.num = b.e - vx - BP_W'(1);
      r.den = b.e - b.g;
    end else if (vx >= b.f) begin
      r.num = BP_W'(1);
      r.den = BP_W'(1);
    end else if (vx >= b.s) begin
      r.num = vx - b.s + BP_W'(1);
      r.den = b.f - b.s;
    end else begin
      r.num = '0;
      r.den = BP_W'(1);
    end
    return r;
  endfunction

  // Valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  // Ratios
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_CHAN; i++) begin
        ratio[i] <= trap_member(bp[i], pix[i]);
      end
    end
  end

endmodule

@@ rtl/core/tcm_product.sv @@
// ----------------------------------------------------------------------------
// tcm_product - products of the three memberships and scaling by 255
// Three stages: pairwise product, triple product, numerator times 255.
// ----------------------------------------------------------------------------
module tcm_product import tcm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  ratio_t              ratio [NUM_CHAN],
  output logic                out_valid,
  output logic [SCALED_W-1:0] scaled_num,
  output logic [PROD3_W-1:0]  den
);

  logic [2:0]          vld;
  logic [PROD2_W-1:0]  num01;
  logic [PROD2_W-1:0]  den01;
  ratio_t              r2;
  logic [PROD3_W-1:0]  num012;
  logic [PROD3_W-1:0]  den012;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // Stage A: channel 0 times channel 1
  always_ff @(posedge clk) begin
    if (adv) begin
      num01 <= PROD2_W'(ratio[0].num) * PROD2_W'(ratio[1].num);
      den01 <= PROD2_W'(ratio[0].den) * PROD2_W'(ratio[1].den);
      r2    <= ratio[2];
    end
  end

  // Stage B: times channel 2
  always_ff @(posedge clk) begin
    if (adv) begin
      num012 <= PROD3_W'(num01) * PROD3_W'(r2.num);
      den012 <= PROD3_W'(den01) * PROD3_W'(r2.den);
    end
  end

  // Stage C: 255 * num as (num << 8) - num
  always_ff @(posedge clk) begin
    if (adv) begin
      scaled_num <= {num012, SCORE_W'(0)} - SCALED_W'(num012);
      den        <= den012;
    end
  end

  assign out_valid = vld[2];

endmodule

@@ rtl/core/tcm_divider.sv @@
// ----------------------------------------------------------------------------
// tcm_divider - pipelined restoring divider, one quotient bit per stage
// Numerator is below 256 times the denominator, so the quotient fits 8 bits.
// ----------------------------------------------------------------------------
module tcm_divider import tcm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [SCALED_W-1:0] num,
  input  logic [PROD3_W-1:0]  den,
  output logic                out_valid,
  output logic [SCORE_W-1:0]  quotient
);

  // Stage registers; the last stage keeps only quotient and valid
  logic [SCALED_W-1:0] rem_q [DIV_STAGES-1];
  logic [PROD3_W-1:0]  den_q [DIV_STAGES-1];
  logic [SCORE_W-1:0]  quo_q [DIV_STAGES];
  logic                vld_q [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - i;

    logic [SCALED_W-1:0] rem_src;
    logic [PROD3_W-1:0]  den_src;
    logic [SCORE_W-1:0]  quo_src;
    logic                vld_src;
    logic [SCALED_W-1:0] den_shift;
    logic                take;

    // Source: the ports for the first stage, the previous stage otherwise
    if (i == 0) begin : g_first
      assign rem_src = num;
      assign den_src = den;
      assign quo_src = '0;
      assign vld_src = in_valid;
    end else begin : g_next
      assign rem_src = rem_q[i-1];
      assign den_src = den_q[i-1];
      assign quo_src = quo_q[i-1];
      assign vld_src = vld_q[i-1];
    end

    // Trial subtract of den << K
    assign den_shift = SCALED_W'(den_src) << K;
    assign take      = (rem_src >= den_shift);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i] <= 1'b0;
      end else if (adv) begin
        vld_q[i] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_q[i] <= quo_src | (SCORE_W'(take) << K);
      end
    end

    if (i < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_q[i] <= take ? (rem_src - den_shift) : rem_src;
          den_q[i] <= den_src;
        end
      end
    end
  end

  assign out_valid = vld_q[DIV_STAGES-1];
  assign quotient  = quo_q[DIV_STAGES-1];

endmodule

@@ rtl/core/trapezoid_color_membership.sv @@
// ----------------------------------------------------------------------------
// trapezoid_color_membership - fuzzy colour score of one Lab pixel
// Trapezoid membership per channel, product of the three, and
// floor(255 * product) by exact integer division.
// ----------------------------------------------------------------------------
//  channel  signals                                  direction
//  in       in_valid/in_ready, lum_value, chroma_a,  into block
//           chroma_b
//  out      out_valid/out_ready, membership_score    out of block
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data into block
//
// One item per clock while results are taken; membership stage, two multiplier
// stages, scale stage and eight divider stages, one quotient bit each.
// The whole pipeline holds while the output register is full and not taken,
// so in_ready follows out_ready combinationally.
// Reset (synchronous) empties the pipeline and loads the default breakpoints;
// no item or register write is taken while rst is high.
// ----------------------------------------------------------------------------
module trapezoid_color_membership import tcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     lum_value,
  input  logic [PIX_W-1:0]     chroma_a,
  input  logic [PIX_W-1:0]     chroma_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SCORE_W-1:0]   membership_score,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  bp_t                 bp [NUM_CHAN];
  pix_t                pix [NUM_CHAN];
  logic                adv;
  logic                mem_valid;
  ratio_t              ratio [NUM_CHAN];
  logic                prod_valid;
  logic [SCALED_W-1:0] scaled_num;
  logic [PROD3_W-1:0]  den;

  // Pipeline moves whenever the output register is free or being taken
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv && !rst;
  assign cfg_ready = !rst;

  // Breakpoint registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bp[0] <= CHAN0_BP_RST;
      bp[1] <= CHAN1_BP_RST;
      bp[2] <= CHAN2_BP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHAN0: bp[0] <= cfg_data;
        CFG_CHAN1: bp[1] <= cfg_data;
        CFG_CHAN2: bp[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pix[0] = lum_value;
  assign pix[1] = chroma_a;
  assign pix[2] = chroma_b;

  // Stage 1: memberships
  tcm_member_stage u_member (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid && in_ready),
    .pix       (pix),
    .bp        (bp),
    .out_valid (mem_valid),
    .ratio     (ratio)
  );

  // Stages 2-4: products and scaling
  tcm_product u_product (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (mem_valid),
    .ratio      (ratio),
    .out_valid  (prod_valid),
    .scaled_num (scaled_num),
    .den        (den)
  );

  // Stages 5-12: division; last stage is the output register
  tcm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (prod_valid),
    .num       (scaled_num),
    .den       (den),
    .out_valid (out_valid),
    .quotient  (membership_score)
  );

endmodule

@@ rtl/core/tcm_checker.sv @@
// ----------------------------------------------------------------------------
// tcm_checker - port-level checks for trapezoid_color_membership
// Output hold, reset, ready relation and fixed latency without stalls.
// ----------------------------------------------------------------------------
module tcm_checker import tcm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SCORE_W-1:0] membership_score
);

  // Tracks each accepted item along a PIPE_DEPTH-bit shift, dropped when out_ready is low
  logic [PIPE_DEPTH-1:0] run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else begin
      run <= {run[PIPE_DEPTH-2:0] & {(PIPE_DEPTH-1){out_ready}}, in_valid && in_ready};
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(membership_score))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  // Input taken exactly when the pipeline can move
  a_ready: assert property (@(posedge clk)
    in_ready == (!rst && (!out_valid || out_ready)))
    else $error("in_ready does not follow the output side");

  // Without stalls an item tracked to the end of run is at the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    run[PIPE_DEPTH-1] && out_ready |-> out_valid)
    else $error("item missing at the expected cycle");

endmodule

bind trapezoid_color_membership tcm_checker u_tcm_checker (.*);

@@ dv/trapezoid_color_membership_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_color_membership_tb - self-checking bench for the colour score
// Drives Lab pixels through the valid/ready stream and compares every score
// with a typed-in value or exact integer floor(255 * m0 * m1 * m2) under
// the breakpoints last written. Covers reset defaults, all-zero and all-ones
// breakpoints, breakpoints above 255, unordered breakpoints, an ignored
// register index, random settings, and idling on either side.
// ----------------------------------------------------------------------------
module trapezoid_color_membership_tb;
  import tcm_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int TIMEOUT_NS  = 400_000 * 2 * HALF_PERIOD;
  localparam int SETTLE      = PIPE_DEPTH + 8;
  localparam int USE_MODEL   = -1;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    pix_t lum;
    pix_t ca;
    pix_t cb;
    int   want;
  } pixel_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  pix_t                 lum_value = '0;
  pix_t                 chroma_a = '0;
  pix_t                 chroma_b = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [SCORE_W-1:0]   membership_score;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  bp_t                  chan_bp [NUM_CHAN];
  logic [SCORE_W-1:0]   expected_scores [$];
  idle_mode_t           idle_mode = IDLE_NONE;
  int                   err_count = 0;
  int                   n_pixels = 0;
  int                   n_scores = 0;
  int                   n_nonzero = 0;
  int                   n_full = 0;
  int                   n_writes = 0;
  int                   n_settings = 1;

  // directed pixels, reset breakpoints; scores typed in where obvious
  pixel_row_t dir_rows [18] = '{
    '{8'd100, 8'd150, 8'd160, 255},        // all three on the plateau
    '{8'd0,   8'd0,   8'd0,   0},          // all minimum
    '{8'd255, 8'd255, 8'd255, 0},          // all maximum
    '{8'd240, 8'd150, 8'd160, 0},          // lightness at e
    '{8'd239, 8'd150, 8'd160, 0},          // last step of falling ramp
    '{8'd150, 8'd150, 8'd160, USE_MODEL},  // top of falling ramp
    '{8'd10,  8'd150, 8'd160, 3},          // lightness at s: 255/70
    '{8'd9,   8'd150, 8'd160, 0},          // just below s
    '{8'd79,  8'd150, 8'd160, 255},        // top of rising ramp
    '{8'd80,  8'd150, 8'd160, 255},        // lightness at f
    '{8'd100, 8'd130, 8'd160, 25},         // a at s: 255/10
    '{8'd100, 8'd150, 8'd130, 12},         // b at s: 255/20
    '{8'd100, 8'd174, 8'd160, 0},          // a just below e
    '{8'd100, 8'd159, 8'd169, 255},        // both chroma just below g
    '{8'd100, 8'd160, 8'd160, USE_MODEL},  // a at g
    '{8'd150, 8'd130, 8'd130, USE_MODEL},  // three ramps at once
    '{8'd200, 8'd165, 8'd172, USE_MODEL},
    '{8'd128, 8'd127, 8'd128, 0}           // a below s
  };

  trapezoid_color_membership u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .lum_value        (lum_value),
    .chroma_a         (chroma_a),
    .chroma_b         (chroma_b),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .membership_score (membership_score),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------- predictor
  // trapezoid membership of one channel value as num/den
  function automatic void trap_ratio(input bp_t bp, input pix_t v,
                                     output longint num, output longint den);
    num = 0;
    den = 1;
    if (v >= bp.e) begin
      num = 0;
    end else if (v >= bp.g) begin
      num = longint'(bp.e) - longint'(v) - 1;
      den = longint'(bp.e) - longint'(bp.g);
    end else if (v >= bp.f) begin
      num = 1;
    end else if (v >= bp.s) begin
      num = longint'(v) - longint'(bp.s) + 1;
      den = longint'(bp.f) - longint'(bp.s);
    end
  endfunction

  // floor(255 * product of memberships), exact
  function automatic logic [SCORE_W-1:0] score_of_pixel(input pix_t l, ca, cb);
    pix_t   px [NUM_CHAN];
    longint num;
    longint den;
    longint n;
    longint d;
    longint q;
    px[0] = l;
    px[1] = ca;
    px[2] = cb;
    num = 255;
    den = 1;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      trap_ratio(chan_bp[ch], px[ch], n, d);
      num = num * n;
      den = den * d;
    end
    q = num / den;
    if (q > 255) q = 255;
    return q[SCORE_W-1:0];
  endfunction

  // ---------------------------------------------------------------- idling
  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99, 0) < 54;
      IDLE_BOTH:   return $urandom_range(99, 0) < 34;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99, 0) < 54;
      IDLE_BOTH:     return $urandom_range(99, 0) < 34;
      default:       return 1'b0;
    endcase
  endfunction

  always @(negedge clk) begin
    out_ready <= !receiver_stalls();
  end

  // ---------------------------------------------------------------- score check
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_scores++;
      if (membership_score != 0) n_nonzero++;
      if (membership_score == 8'd255) n_full++;
      if (expected_scores.size() == 0) begin
        $error("membership_score: expected none, actual %0d", membership_score);
        err_count++;
      end else begin
        if (membership_score !== expected_scores[0]) begin
          $error("membership_score: expected %0d, actual %0d",
                 expected_scores[0], membership_score);
          err_count++;
        end
        void'(expected_scores.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // one pixel item; want < 0 means the predictor supplies the score
  task automatic send_pixel(input pix_t l, ca, cb, input int want);
    @(negedge clk);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    lum_value <= l;
    chroma_a  <= ca;
    chroma_b  <= cb;
    do @(posedge clk); while (!in_ready);
    n_pixels++;
    if (want < 0) expected_scores = {expected_scores, score_of_pixel(l, ca, cb)};
    else expected_scores = {expected_scores, want[SCORE_W-1:0]};
  endtask

  // sender goes quiet until every outstanding score is back
  task automatic hold_until_empty();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    n_writes++;
    case (idx)
      CFG_CHAN0: chan_bp[0] = data;
      CFG_CHAN1: chan_bp[1] = data;
      CFG_CHAN2: chan_bp[2] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain, then load all channels; a write to the unused index goes first
  task automatic set_channels(input bp_t c0, c1, c2);
    hold_until_empty();
    repeat (SETTLE) @(posedge clk);
    write_reg(CFG_UNUSED, REG_W'({$urandom, $urandom}));
    write_reg(CFG_CHAN0, c0);
    write_reg(CFG_CHAN1, c1);
    write_reg(CFG_CHAN2, c2);
    n_settings++;
  endtask

  function automatic bp_t make_bp(input logic [BP_W-1:0] s, f, g, e);
    return {e, g, f, s};
  endfunction

  // mostly ordered breakpoints around the pixel range, sometimes anything
  function automatic bp_t random_bp();
    int v [4];
    int t;
    if ($urandom_range(3, 0) == 0) return REG_W'({$urandom, $urandom});
    for (int i = 0; i < 4; i++) v[i] = $urandom_range(300, 0);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
      end
    end
    return make_bp(BP_W'(v[0]), BP_W'(v[1]), BP_W'(v[2]), BP_W'(v[3]));
  endfunction

  // value near the support of a channel, or anywhere now and then
  function automatic pix_t random_value(input bp_t bp);
    int lo;
    int hi;
    lo = (bp.s > 2) ? int'(bp.s) - 2 : 0;
    hi = (bp.e < 255) ? int'(bp.e) + 1 : 255;
    if (lo > 255 || lo > hi || $urandom_range(4, 0) == 0) begin
      return pix_t'($urandom_range(255, 0));
    end
    return pix_t'($urandom_range(hi, lo));
  endfunction

  task automatic send_random(input int count);
    repeat (count) begin
      send_pixel(random_value(chan_bp[0]), random_value(chan_bp[1]),
                 random_value(chan_bp[2]), USE_MODEL);
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    chan_bp[0] = CHAN0_BP_RST;
    chan_bp[1] = CHAN1_BP_RST;
    chan_bp[2] = CHAN2_BP_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset breakpoints: table, then random with a full drain halfway
    foreach (dir_rows[i]) send_pixel(dir_rows[i].lum, dir_rows[i].ca, dir_rows[i].cb,
                                     dir_rows[i].want);
    send_random(30);
    hold_until_empty();
    send_random(30);

    // all breakpoints zero: every pixel is past e
    idle_mode = IDLE_SENDER;
    set_channels('0, '0, '0);
    send_pixel(8'd0, 8'd0, 8'd0, 0);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_random(28);

    // all breakpoints 511: every pixel is below s
    idle_mode = IDLE_RECEIVER;
    set_channels('1, '1, '1);
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_random(29);

    // breakpoints above 255: pixel 255 lands on a ramp
    idle_mode = IDLE_BOTH;
    set_channels(make_bp(9'd0, 9'd0, 9'd0, 9'd256), make_bp(9'd0, 9'd128, 9'd128, 9'd300),
                 make_bp(9'd0, 9'd256, 9'd300, 9'd400));
    send_pixel(8'd255, 8'd255, 8'd255, 0);
    send_pixel(8'd0, 8'd0, 8'd255, USE_MODEL);
    send_pixel(8'd254, 8'd200, 8'd128, USE_MODEL);
    send_random(57);

    // unordered breakpoints
    idle_mode = IDLE_NONE;
    set_channels(make_bp(9'd200, 9'd100, 9'd50, 9'd150), make_bp(9'd255, 9'd10, 9'd100, 9'd90),
                 make_bp(9'd0, 9'd255, 9'd255, 9'd255));
    send_random(40);

    // random settings, cycling through the idle patterns
    for (int p = 0; p < 5; p++) begin
      idle_mode = idle_mode_t'((p + 1) % 4);
      set_channels(random_bp(), random_bp(), random_bp());
      send_random(45);
    end

    hold_until_empty();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d pixels under %0d breakpoint settings (%0d register writes).",
             n_pixels, n_settings, n_writes);
    $display("Checked %0d scores: %0d nonzero, %0d at full scale.",
             n_scores, n_nonzero, n_full);
    if (err_count == 0) begin
      $display("[trapezoid_color_membership] OK");
    end else begin
      $display("[trapezoid_color_membership] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("[trapezoid_color_membership] ERROR");
    $finish;
  end

endmodule
